// ===== rtl/core/gczs_pkg.sv =====
// ---------------------------------------------------------------------------
// gczs_pkg
// shared types and constants of the grid cell extreme z selector
// ---------------------------------------------------------------------------
`default_nettype none

package gczs_pkg;

  localparam int COORD_BITS = 32;
  localparam int Z_BITS     = 32;
  localparam int ID_BITS    = 32;
  localparam int IDX_BITS   = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int CS_BITS    = 31;
  localparam int GRID_BITS  = 9;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_MAX     = 3'd5;

  localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
  localparam logic [1:0] CMD_QUERY      = 2'd1;
  localparam logic [1:0] CMD_CLEAR      = 2'd2;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0]            command;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [Z_BITS-1:0]     z;
    logic [ID_BITS-1:0]    point_id;
  } in_t;

  typedef struct packed {
    logic                kept;
    logic                out_of_range;
    logic [IDX_BITS-1:0] cell_index;
  } res_t;

  typedef struct packed {
    logic               occupied;
    logic [Z_BITS-1:0]  best_z;
    logic [ID_BITS-1:0] best_id;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/gczs_ram.sv =====
// ---------------------------------------------------------------------------
// gczs_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module gczs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gczs_div.sv =====
// ---------------------------------------------------------------------------
// gczs_div
// bit-serial restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module gczs_div #(
  parameter int DW = 33,
  parameter int VW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          fits;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DW-1]};
    fits    = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/grid_cell_extreme_z_selector.sv =====
// ---------------------------------------------------------------------------
// grid_cell_extreme_z_selector
// point cloud grid decimation keeping the highest or lowest z per cell
// ---------------------------------------------------------------------------
// in_* carries one transaction per item: accumulate a point, query whether a
// point id is its cell's keeper, or clear all cells. every transaction gives
// exactly one result transaction on out_*. cfg_* writes the grid setup; the
// user must write it only while the block is idle (not enforced by the block).
// one item at a time: an accumulate or query runs through the bit-serial
// dividers (x and y in parallel), then index multiply, cell ram read and
// write-back before its result. a point left of or below the origin, and
// the unused command, go straight to the result; a point beyond the grid
// returns its result once the dividers finish.
// a clear sweeps the cell ram one entry per cycle over all MAX_COLUMNS *
// MAX_ROWS entries, then returns its result.
// after reset the same sweep runs with in_ready low; configuration writes
// are taken during it.
// the result sits in an output register: the next item is accepted while it
// waits for out_ready, and a finished item waits only if that register is
// still full.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_cell_extreme_z_selector #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire gczs_pkg::in_t                       in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output gczs_pkg::res_t                           out_data,
  input  wire logic                                cfg_we,
  input  wire logic [gczs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gczs_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LC    = $clog2(MAX_COLUMNS + 1);
  localparam int LR    = $clog2(MAX_ROWS + 1);
  localparam int LCR   = (LC > LR) ? LC : LR;
  localparam int LIM_W = (LCR > gczs_pkg::GRID_BITS) ? LCR : gczs_pkg::GRID_BITS;
  localparam int PW    = ROW_W + LIM_W + 1;
  localparam int IW    = (PW > gczs_pkg::IDX_BITS) ? PW : gczs_pkg::IDX_BITS;
  localparam int DW    = gczs_pkg::DIFF_W;
  localparam int EW    = $bits(gczs_pkg::entry_t);

  // configuration
  logic [31:0]                       origin_x_r, origin_y_r;
  logic [gczs_pkg::CS_BITS-1:0]      cell_size_r;
  logic [gczs_pkg::GRID_BITS-1:0]    grid_columns_r, grid_rows_r;
  logic                              keep_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      cell_size_r    <= gczs_pkg::CS_BITS'(1);
      grid_columns_r <= gczs_pkg::GRID_BITS'(256);
      grid_rows_r    <= gczs_pkg::GRID_BITS'(256);
      keep_max_r     <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gczs_pkg::REG_ORIGIN_X:     origin_x_r     <= cfg_wdata;
        gczs_pkg::REG_ORIGIN_Y:     origin_y_r     <= cfg_wdata;
        gczs_pkg::REG_CELL_SIZE:    cell_size_r    <= cfg_wdata[gczs_pkg::CS_BITS-1:0];
        gczs_pkg::REG_GRID_COLUMNS: grid_columns_r <= cfg_wdata[gczs_pkg::GRID_BITS-1:0];
        gczs_pkg::REG_GRID_ROWS:    grid_rows_r    <= cfg_wdata[gczs_pkg::GRID_BITS-1:0];
        gczs_pkg::REG_KEEP_MAX:     keep_max_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // grid limits
  logic [LIM_W-1:0] gc_ext, gr_ext, max_c, max_r, cols, rows;
  always_comb begin
    gc_ext = LIM_W'(grid_columns_r);
    gr_ext = LIM_W'(grid_rows_r);
    max_c  = LIM_W'(MAX_COLUMNS);
    max_r  = LIM_W'(MAX_ROWS);
    cols   = (gc_ext > max_c) ? max_c : gc_ext;
    rows   = (gr_ext > max_r) ? max_r : gr_ext;
  end

  // offsets from the origin
  logic [DW:0] dx, dy;
  logic        pre_oor;
  logic        in_oor;
  always_comb begin
    dx = {{2{in_data.x[gczs_pkg::COORD_BITS-1]}}, in_data.x}
       - {{2{origin_x_r[31]}}, origin_x_r};
    dy = {{2{in_data.y[gczs_pkg::COORD_BITS-1]}}, in_data.y}
       - {{2{origin_y_r[31]}}, origin_y_r};
    pre_oor = (cell_size_r == '0) || (cols == '0) || (rows == '0) || dx[DW] || dy[DW];
    in_oor  = pre_oor && (in_data.command == gczs_pkg::CMD_ACCUMULATE
                          || in_data.command == gczs_pkg::CMD_QUERY);
  end

  // state
  gczs_pkg::state_t state_r, state_nxt;
  gczs_pkg::in_t    item_r;
  gczs_pkg::res_t   res_r;
  gczs_pkg::res_t   out_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic             clr_reply_r;
  logic [AW-1:0]    clr_addr_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [AW-1:0]    idx_r;

  logic             in_fire;
  logic             div_start;
  logic             div_done_x, div_done_y;
  logic [DW-1:0]    qx, qy;
  logic             q_oor;
  logic [PW-1:0]    idx_sum;
  logic [IW-1:0]    idx_ext;
  logic             clr_last;
  logic             out_free;

  gczs_pkg::entry_t rd_entry, wr_entry;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [EW-1:0]    mem_rdata;
  logic             take;
  logic             z_better;

  assign in_fire   = in_valid && in_ready;
  assign div_start = in_fire && !pre_oor && (in_data.command == gczs_pkg::CMD_ACCUMULATE
                     || in_data.command == gczs_pkg::CMD_QUERY);

  gczs_div #(.DW(DW), .VW(gczs_pkg::CS_BITS)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dx[DW-1:0]),
    .divisor  (cell_size_r),
    .done     (div_done_x),
    .quotient (qx)
  );

  gczs_div #(.DW(DW), .VW(gczs_pkg::CS_BITS)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dy[DW-1:0]),
    .divisor  (cell_size_r),
    .done     (div_done_y),
    .quotient (qy)
  );

  gczs_ram #(.WIDTH(EW), .DEPTH(CELL_COUNT)) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_entry),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    q_oor    = (qx >= DW'(cols)) || (qy >= DW'(rows));
    idx_sum  = PW'(row_r) * PW'(cols) + PW'(col_r);
    idx_ext  = IW'(idx_sum);
    clr_last = (clr_addr_r == AW'(CELL_COUNT - 1));
    out_free = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r && !out_ready;
    if (state_r == gczs_pkg::ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end
    rd_entry = mem_rdata;
    z_better = keep_max_r ? ($signed(item_r.z) > $signed(rd_entry.best_z))
                          : ($signed(item_r.z) < $signed(rd_entry.best_z));
    take     = (item_r.command == gczs_pkg::CMD_ACCUMULATE)
               && (!rd_entry.occupied || z_better);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gczs_pkg::ST_CLEAR: if (clr_last) state_nxt = clr_reply_r ? gczs_pkg::ST_DONE
                                                                 : gczs_pkg::ST_IDLE;
      gczs_pkg::ST_IDLE: begin
        if (in_valid) begin
          priority if (in_data.command == gczs_pkg::CMD_CLEAR) state_nxt = gczs_pkg::ST_CLEAR;
          else if (div_start) state_nxt = gczs_pkg::ST_DIV;
          else state_nxt = gczs_pkg::ST_DONE;
        end
      end
      gczs_pkg::ST_DIV: if (div_done_x && div_done_y) state_nxt = q_oor ? gczs_pkg::ST_DONE
                                                                          : gczs_pkg::ST_MUL;
      gczs_pkg::ST_MUL:  state_nxt = gczs_pkg::ST_READ;
      gczs_pkg::ST_READ: state_nxt = gczs_pkg::ST_CMP;
      gczs_pkg::ST_CMP:  state_nxt = gczs_pkg::ST_DONE;
      gczs_pkg::ST_DONE: if (out_free) state_nxt = gczs_pkg::ST_IDLE;
      default: state_nxt = gczs_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_raddr = idx_r;
    wr_entry  = '{occupied: 1'b1, best_z: item_r.z, best_id: item_r.point_id};
    unique case (state_r)
      gczs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        wr_entry  = '0;
      end
      gczs_pkg::ST_IDLE: in_ready = 1'b1;
      gczs_pkg::ST_CMP:  mem_we = take;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gczs_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        gczs_pkg::ST_CLEAR: clr_addr_r <= clr_last ? '0 : clr_addr_r + 1'b1;
        gczs_pkg::ST_IDLE: if (in_fire) clr_reply_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      gczs_pkg::ST_IDLE: begin
        if (in_fire) begin
          item_r <= in_data;
          res_r  <= '{kept: 1'b0, out_of_range: in_oor, cell_index: '0};
        end
      end
      gczs_pkg::ST_DIV: begin
        if (div_done_x && div_done_y) begin
          res_r.out_of_range <= q_oor;
          col_r <= qx[COL_W-1:0];
          row_r <= qy[ROW_W-1:0];
        end
      end
      gczs_pkg::ST_MUL: begin
        idx_r            <= idx_sum[AW-1:0];
        res_r.cell_index <= idx_ext[gczs_pkg::IDX_BITS-1:0];
      end
      gczs_pkg::ST_CMP: begin
        res_r.kept <= (item_r.command == gczs_pkg::CMD_QUERY)
                      ? (rd_entry.occupied && rd_entry.best_id == item_r.point_id)
                      : take;
      end
      gczs_pkg::ST_DONE: if (out_free) out_data_r <= res_r;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/gczs_checker.sv =====
// ---------------------------------------------------------------------------
// gczs_checker
// port level checks of the grid cell extreme z selector
// ---------------------------------------------------------------------------
`default_nettype none

module gczs_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire gczs_pkg::res_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in work");

  a_oor_not_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |-> !out_data.kept && out_data.cell_index == '0)
    else $error("out of range result carries a cell");

endmodule

bind grid_cell_extreme_z_selector gczs_checker u_gczs_checker (.*);

`default_nettype wire
